### rtl/core/brlt_pkg.sv
// Package for the buffer region lease table: operation and status codes,
// the item types and the engine state enum. No dependencies.
`default_nettype none
package brlt_pkg;

    typedef enum logic [2:0] {
        OP_ADD     = 3'd0,
        OP_REMOVE  = 3'd1,
        OP_ACQ_LOC = 3'd2,
        OP_ACQ_REM = 3'd3,
        OP_RELEASE = 3'd4,
        OP_CLOSE   = 3'd5,
        OP_REOPEN  = 3'd6,
        OP_QUERY   = 3'd7
    } op_t;

    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_BAD_RANGE   = 4'd1;
    localparam logic [3:0] ST_BAD_MODE    = 4'd2;
    localparam logic [3:0] ST_OVERLAP     = 4'd3;
    localparam logic [3:0] ST_SHUTDOWN    = 4'd4;
    localparam logic [3:0] ST_NOT_REG     = 4'd5;
    localparam logic [3:0] ST_STALE_ID    = 4'd6;
    localparam logic [3:0] ST_DENIED      = 4'd7;
    localparam logic [3:0] ST_IDS_EXHAUST = 4'd8;
    localparam logic [3:0] ST_TABLE_FULL  = 4'd9;
    localparam logic [3:0] ST_LEASE_FULL  = 4'd10;
    localparam logic [3:0] ST_REM_PENDING = 4'd11;
    localparam logic [3:0] ST_REOPEN_REF  = 4'd12;

    localparam logic [1:0] MODE_LOCAL_RW  = 2'd0;
    localparam logic [1:0] MODE_GLOBAL_RW = 2'd2;
    localparam logic [1:0] MODE_INVALID   = 2'd3;

    // Classified request passed from the front end to the engine
    typedef struct packed {
        op_t         kind;
        logic [63:0] address;
        logic [63:0] byte_length;
        logic [63:0] range_end;
        logic        range_bad;
        logic [1:0]  access_mode;
        logic [63:0] presented_id;
        logic        is_write;
        logic [3:0]  lease_slot;
    } req_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [63:0] assigned_id;
        logic [3:0]  handle_slot;
        logic [63:0] region_base;
        logic [63:0] region_length;
        logic        is_tracked;
        logic        drain_done;
    } rsp_t;

    typedef enum logic [2:0] {
        EN_IDLE,
        EN_SCAN,
        EN_DECIDE,
        EN_ID2,
        EN_DONE
    } eng_state_t;

endpackage
`default_nettype wire

### rtl/core/brlt_front.sv
// Front end: accepts requests, precomputes the range end and queues them.
// Depends on brlt_pkg.
`default_nettype none
module brlt_front
    import brlt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  kind,
    input  wire logic [63:0] address,
    input  wire logic [63:0] byte_length,
    input  wire logic [1:0]  access_mode,
    input  wire logic [63:0] presented_id,
    input  wire logic        is_write,
    input  wire logic [3:0]  lease_slot,
    output logic             req_valid,
    output req_t             req,
    input  wire logic        req_take
);
    req_t q_reg [2];
    logic [1:0] cnt_reg;
    logic       wp_reg, rp_reg;
    logic [64:0] sum;
    req_t nreq;
    logic do_push, do_pop;

    // Classify range: zero length or carry out means bad
    always_comb
    begin
        sum = {1'b0, address} + {1'b0, byte_length};
        nreq.kind            = op_t'(kind);
        nreq.address         = address;
        nreq.byte_length     = byte_length;
        nreq.range_end       = sum[63:0];
        nreq.range_bad       = (byte_length == 64'd0) || sum[64];
        nreq.access_mode     = access_mode;
        nreq.presented_id    = presented_id;
        nreq.is_write        = is_write;
        nreq.lease_slot      = lease_slot;
    end

    assign full      = (cnt_reg == 2'd2);
    assign req_valid = (cnt_reg != 2'd0);
    assign req       = q_reg[rp_reg];
    assign do_push   = push && !full;
    assign do_pop    = req_take && req_valid;

    // Two-entry queue between front and engine
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wp_reg] <= nreq;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            if (do_push) wp_reg <= ~wp_reg;
            if (do_pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end
endmodule
`default_nettype wire

### rtl/core/brlt_engine.sv
// Back end: scans the slot table one entry per cycle and applies the request.
// Depends on brlt_pkg.
`default_nettype none
module brlt_engine
    import brlt_pkg::*;
#(
    parameter int ENTRIES    = 16,
    parameter int LEASE_BITS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [63:0] id_namespace,
    input  wire logic        req_valid,
    input  wire req_t        req,
    output logic             req_take,
    output logic             rsp_valid,
    output rsp_t             rsp,
    input  wire logic        rsp_ready
);
    localparam int IW = $clog2(ENTRIES);
    localparam logic [IW:0] LAST = (IW + 1)'(ENTRIES - 1);

    logic [63:0] base_reg [ENTRIES];
    logic [63:0] len_reg  [ENTRIES];
    logic [1:0]  mode_reg [ENTRIES];
    logic [63:0] id_reg   [ENTRIES];
    logic [LEASE_BITS-1:0] lease_reg [ENTRIES];
    logic [ENTRIES-1:0] used_reg, vis_reg;
    logic [63:0] seq_reg;
    logic        shut_reg;

    eng_state_t state_reg, state_next;
    req_t        r_reg;
    logic [IW-1:0] idx_reg;
    logic        hit_reg, free_f_reg, ovl_reg;
    logic [IW-1:0] hit_reg_i, free_reg_i;
    rsp_t        rsp_reg;
    logic        rsp_valid_reg;

    // Per-slot values at the scan index
    logic [63:0] s_base, s_len, s_end;
    logic        s_used, s_vis, s_live;
    logic        m_exact, m_ovl, m_cont;
    logic [IW-1:0] rel_i;
    logic        rel_in;

    always_comb
    begin
        s_base = base_reg[idx_reg];
        s_len  = len_reg[idx_reg];
        s_end  = s_base + s_len;
        s_used = used_reg[idx_reg];
        s_vis  = vis_reg[idx_reg];
        s_live = s_used && s_vis;
        m_exact = s_live && (s_base == r_reg.address) && (s_len == r_reg.byte_length);
        m_ovl   = s_live && (r_reg.address < s_end) && (s_base < r_reg.range_end);
        m_cont  = s_live && (r_reg.address >= s_base) && (r_reg.range_end <= s_end);
        rel_i   = IW'(r_reg.lease_slot);
        rel_in  = ({1'b0, r_reg.lease_slot} < 5'(ENTRIES)) || (IW > 4);
    end

    assign req_take  = (state_reg == EN_IDLE) && !rsp_valid_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            EN_IDLE:   if (req_valid && !rsp_valid_reg) state_next = EN_SCAN;
            EN_SCAN:   if ({1'b0, idx_reg} == LAST) state_next = EN_DECIDE;
            EN_DECIDE: state_next = EN_ID2;
            EN_ID2:    state_next = EN_DONE;
            EN_DONE:   state_next = EN_IDLE;
            default:   state_next = EN_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= EN_IDLE;
        else        state_reg <= state_next;
    end

    // Decide and write back
    logic [63:0] id_a, id_b, seq_a;
    logic [IW-1:0] hs;
    always_comb
    begin
        id_a  = id_namespace ^ seq_reg;
        seq_a = seq_reg + 64'd1;
        id_b  = id_namespace ^ seq_a;
        hs    = hit_reg_i;
    end

    // Store the new region only once the add has succeeded
    always_ff @(posedge clk)
    begin
        if (req_take && req_valid) r_reg <= req;
        if (state_reg == EN_ID2 && r_reg.kind == OP_ADD && rsp_reg.status == ST_OK)
        begin
            base_reg[free_reg_i] <= r_reg.address;
            len_reg[free_reg_i]  <= r_reg.byte_length;
            mode_reg[free_reg_i] <= r_reg.access_mode;
            id_reg[free_reg_i]   <= rsp_reg.assigned_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            vis_reg  <= '0;
            for (int i = 0; i < ENTRIES; i++) lease_reg[i] <= '0;
            seq_reg  <= 64'd1;
            shut_reg <= 1'b0;
            idx_reg  <= '0;
            hit_reg  <= 1'b0;
            free_f_reg <= 1'b0;
            ovl_reg  <= 1'b0;
            hit_reg_i  <= '0;
            free_reg_i <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg  <= '0;
        end
        else
        begin
            if (rsp_valid_reg && rsp_ready) rsp_valid_reg <= 1'b0;
            case (state_reg)
                EN_IDLE:
                begin
                    idx_reg <= '0;
                    hit_reg <= 1'b0;
                    free_f_reg <= 1'b0;
                    ovl_reg <= 1'b0;
                    // Hold the waiting result until it is taken
                    if (!rsp_valid_reg) rsp_reg <= '0;
                end
                EN_SCAN:
                begin
                    // Record the first match and first free slot
                    if (!s_used && !free_f_reg)
                    begin
                        free_f_reg <= 1'b1;
                        free_reg_i <= idx_reg;
                    end
                    if (m_ovl) ovl_reg <= 1'b1;
                    if (!hit_reg && (((r_reg.kind == OP_REMOVE ||
                        r_reg.kind == OP_QUERY) && m_exact) ||
                        ((r_reg.kind == OP_ACQ_LOC || r_reg.kind == OP_ACQ_REM) && m_cont) ||
                        (r_reg.kind == OP_REOPEN && s_live)))
                    begin
                        hit_reg   <= 1'b1;
                        hit_reg_i <= idx_reg;
                    end
                    idx_reg <= idx_reg + IW'(1);
                end
                EN_DECIDE:
                begin
                    case (r_reg.kind)
                        OP_ADD:
                        begin
                            if (r_reg.range_bad) rsp_reg.status <= ST_BAD_RANGE;
                            else if (r_reg.access_mode == MODE_INVALID)
                                rsp_reg.status <= ST_BAD_MODE;
                            else if (shut_reg) rsp_reg.status <= ST_SHUTDOWN;
                            else if (ovl_reg) rsp_reg.status <= ST_OVERLAP;
                            else if (!free_f_reg) rsp_reg.status <= ST_TABLE_FULL;
                            else if (seq_reg == 64'd0 || seq_reg == '1)
                                rsp_reg.status <= ST_IDS_EXHAUST;
                            else if (id_a == 64'd0 && seq_a == '1)
                            begin
                                rsp_reg.status <= ST_IDS_EXHAUST;
                                seq_reg <= seq_a;
                            end
                            else
                            begin
                                rsp_reg.status <= ST_OK;
                                rsp_reg.assigned_id <= (id_a == 64'd0) ? id_b : id_a;
                                seq_reg <= (id_a == 64'd0) ? seq_a + 64'd1 : seq_a;
                                rsp_reg.handle_slot <= 4'(free_reg_i);
                                used_reg[free_reg_i] <= 1'b1;
                                vis_reg[free_reg_i]  <= 1'b1;
                                lease_reg[free_reg_i] <= '0;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (!hit_reg) rsp_reg.status <= ST_NOT_REG;
                            else
                            begin
                                vis_reg[hs] <= 1'b0;
                                rsp_reg.handle_slot <= 4'(hs);
                                if (lease_reg[hs] == '0)
                                begin
                                    used_reg[hs] <= 1'b0;
                                    rsp_reg.drain_done <= 1'b1;
                                    rsp_reg.status <= ST_OK;
                                end
                                else rsp_reg.status <= ST_REM_PENDING;
                            end
                        end
                        OP_ACQ_LOC, OP_ACQ_REM:
                        begin
                            if (r_reg.range_bad) rsp_reg.status <= ST_BAD_RANGE;
                            else if (shut_reg) rsp_reg.status <= ST_SHUTDOWN;
                            else if (!hit_reg) rsp_reg.status <= ST_NOT_REG;
                            else if (r_reg.kind == OP_ACQ_REM &&
                                     id_reg[hs] != r_reg.presented_id)
                                rsp_reg.status <= ST_STALE_ID;
                            else if (r_reg.kind == OP_ACQ_REM &&
                                     (mode_reg[hs] == MODE_LOCAL_RW ||
                                      (r_reg.is_write && mode_reg[hs] != MODE_GLOBAL_RW)))
                                rsp_reg.status <= ST_DENIED;
                            else if (lease_reg[hs] == '1)
                                rsp_reg.status <= ST_LEASE_FULL;
                            else
                            begin
                                lease_reg[hs] <= lease_reg[hs] + LEASE_BITS'(1);
                                rsp_reg.status <= ST_OK;
                                rsp_reg.handle_slot <= 4'(hs);
                                rsp_reg.region_base <= base_reg[hs];
                                rsp_reg.region_length <= len_reg[hs];
                            end
                        end
                        OP_RELEASE:
                        begin
                            rsp_reg.handle_slot <= r_reg.lease_slot;
                            if (!rel_in || !used_reg[rel_i] || lease_reg[rel_i] == '0)
                                rsp_reg.status <= ST_NOT_REG;
                            else
                            begin
                                lease_reg[rel_i] <= lease_reg[rel_i] - LEASE_BITS'(1);
                                rsp_reg.status <= ST_OK;
                                if (!vis_reg[rel_i] && lease_reg[rel_i] == LEASE_BITS'(1))
                                begin
                                    used_reg[rel_i] <= 1'b0;
                                    rsp_reg.drain_done <= 1'b1;
                                end
                            end
                        end
                        OP_CLOSE: shut_reg <= 1'b1;
                        OP_REOPEN:
                        begin
                            if (hit_reg) rsp_reg.status <= ST_REOPEN_REF;
                            else shut_reg <= 1'b0;
                        end
                        default: rsp_reg.is_tracked <= hit_reg;
                    endcase
                end
                EN_ID2:  ;
                EN_DONE: rsp_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

### rtl/core/buffer_region_lease_table.sv
// Buffer region lease table top level: front queue, table engine, result register.
// The engine handles one request at a time, scanning the table one slot per
// cycle, and takes no new request until its result has been taken; a
// waiting result stalls the engine. Reset clears all slots, sets the id
// sequence to one, opens the table and clears the namespace.
`default_nettype none
module buffer_region_lease_table
    import brlt_pkg::*;
#(
    parameter int ENTRIES    = 16,
    parameter int LEASE_BITS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  kind,
    input  wire logic [63:0] address,
    input  wire logic [63:0] byte_length,
    input  wire logic [1:0]  access_mode,
    input  wire logic [63:0] presented_id,
    input  wire logic        is_write,
    input  wire logic [3:0]  lease_slot,
    output logic             empty,
    input  wire logic        pop,
    output logic [3:0]       status,
    output logic [63:0]      assigned_id,
    output logic [3:0]       handle_slot,
    output logic [63:0]      region_base,
    output logic [63:0]      region_length,
    output logic             is_tracked,
    output logic             drain_done,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [63:0] cfg_data
);
    logic [63:0] ns_reg;
    logic        req_valid, req_take, rsp_valid;
    req_t        req;
    rsp_t        rsp;

    // Hold the namespace register
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)         ns_reg <= 64'd0;
        else if (cfg_valid) ns_reg <= cfg_data;
    end

    brlt_front u_front (
        .clk, .rst_n, .push, .full, .kind, .address, .byte_length,
        .access_mode, .presented_id, .is_write, .lease_slot,
        .req_valid, .req, .req_take
    );

    brlt_engine #(.ENTRIES(ENTRIES), .LEASE_BITS(LEASE_BITS)) u_engine (
        .clk, .rst_n, .id_namespace(ns_reg), .req_valid, .req, .req_take,
        .rsp_valid, .rsp, .rsp_ready(pop)
    );

    assign empty         = !rsp_valid;
    assign status        = rsp.status;
    assign assigned_id   = rsp.assigned_id;
    assign handle_slot   = rsp.handle_slot;
    assign region_base   = rsp.region_base;
    assign region_length = rsp.region_length;
    assign is_tracked    = rsp.is_tracked;
    assign drain_done    = rsp.drain_done;
endmodule
`default_nettype wire

### tb/buffer_region_lease_table_checker.sv
// Checker for the buffer region lease table: watches the request, result and
// configuration channels, predicts each result and compares it field by field.
// Depends on brlt_pkg for operation, status and mode codes.
module buffer_region_lease_table_checker
    import brlt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [2:0]  kind,
    input  logic [63:0] address,
    input  logic [63:0] byte_length,
    input  logic [1:0]  access_mode,
    input  logic [63:0] presented_id,
    input  logic        is_write,
    input  logic [3:0]  lease_slot,
    input  logic        empty,
    input  logic        pop,
    input  logic [3:0]  status,
    input  logic [63:0] assigned_id,
    input  logic [3:0]  handle_slot,
    input  logic [63:0] region_base,
    input  logic [63:0] region_length,
    input  logic        is_tracked,
    input  logic        drain_done,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [63:0] cfg_data,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = 16;
    localparam logic [63:0] ONES = '1;
    localparam logic [15:0] LEASE_CAP = 16'hFFFF;

    rsp_t        answers_due[$];
    logic [63:0] namespace_q;
    logic        used_q [NSLOT];
    logic        shown_q [NSLOT];
    logic [63:0] base_q [NSLOT];
    logic [63:0] len_q [NSLOT];
    logic [1:0]  mode_q [NSLOT];
    logic [63:0] id_q [NSLOT];
    logic [15:0] leases_q [NSLOT];
    logic [63:0] seq_q;
    logic        closed_q;

    assign pending = answers_due.size();

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        fail_count++;
    endtask

    function automatic int find_exact(input logic [63:0] b, input logic [63:0] l);
        for (int i = 0; i < NSLOT; i++)
            if (used_q[i] && shown_q[i] && base_q[i] == b && len_q[i] == l)
                return i;
        return -1;
    endfunction

    // Work out the answer to one request and advance the table copy
    function automatic rsp_t lease_answer(input op_t op, input logic [63:0] a,
            input logic [63:0] l, input logic [1:0] m, input logic [63:0] rid,
            input logic wr, input logic [3:0] ls);
        rsp_t r;
        logic [63:0] e, id;
        logic rok;
        int s;
        r = '0;
        s = -1;
        rok = (l != 64'd0) && (a <= ONES - l);
        e = a + l;
        case (op)
            OP_ADD:
            begin
                if (!rok) r.status = ST_BAD_RANGE;
                else if (m == MODE_INVALID) r.status = ST_BAD_MODE;
                else if (closed_q) r.status = ST_SHUTDOWN;
                else
                begin
                    for (int i = 0; i < NSLOT; i++)
                    begin
                        if (!used_q[i])
                        begin
                            if (s < 0) s = i;
                        end
                        else if (shown_q[i] && a < base_q[i] + len_q[i] && base_q[i] < e)
                            r.status = ST_OVERLAP;
                    end
                    if (r.status != ST_OK) return r;
                    if (s < 0) r.status = ST_TABLE_FULL;
                    else if (seq_q == 64'd0 || seq_q == ONES) r.status = ST_IDS_EXHAUST;
                    else
                    begin
                        id = namespace_q ^ seq_q;
                        seq_q++;
                        if (id == 64'd0)
                        begin
                            if (seq_q == ONES)
                            begin
                                r.status = ST_IDS_EXHAUST;
                                return r;
                            end
                            id = namespace_q ^ seq_q;
                            seq_q++;
                        end
                        used_q[s] = 1'b1; shown_q[s] = 1'b1; base_q[s] = a; len_q[s] = l;
                        mode_q[s] = m; id_q[s] = id; leases_q[s] = 16'd0;
                        r.assigned_id = id;
                        r.handle_slot = s[3:0];
                    end
                end
            end
            OP_REMOVE:
            begin
                s = find_exact(a, l);
                if (s < 0) r.status = ST_NOT_REG;
                else
                begin
                    shown_q[s] = 1'b0;
                    r.handle_slot = s[3:0];
                    if (leases_q[s] == 16'd0)
                    begin
                        used_q[s] = 1'b0;
                        r.drain_done = 1'b1;
                    end
                    else r.status = ST_REM_PENDING;
                end
            end
            OP_ACQ_LOC, OP_ACQ_REM:
            begin
                if (!rok) r.status = ST_BAD_RANGE;
                else if (closed_q) r.status = ST_SHUTDOWN;
                else
                begin
                    for (int i = 0; i < NSLOT; i++)
                        if (s < 0 && used_q[i] && shown_q[i] && a >= base_q[i]
                                && e <= base_q[i] + len_q[i])
                            s = i;
                    if (s < 0) r.status = ST_NOT_REG;
                    else if (op == OP_ACQ_REM && id_q[s] != rid) r.status = ST_STALE_ID;
                    else if (op == OP_ACQ_REM && (mode_q[s] == MODE_LOCAL_RW
                            || (wr && mode_q[s] != MODE_GLOBAL_RW)))
                        r.status = ST_DENIED;
                    else if (leases_q[s] >= LEASE_CAP) r.status = ST_LEASE_FULL;
                    else
                    begin
                        leases_q[s]++;
                        r.handle_slot = s[3:0];
                        r.region_base = base_q[s];
                        r.region_length = len_q[s];
                    end
                end
            end
            OP_RELEASE:
            begin
                r.handle_slot = ls;
                if (!used_q[ls] || leases_q[ls] == 16'd0) r.status = ST_NOT_REG;
                else
                begin
                    leases_q[ls]--;
                    if (!shown_q[ls] && leases_q[ls] == 16'd0)
                    begin
                        used_q[ls] = 1'b0;
                        r.drain_done = 1'b1;
                    end
                end
            end
            OP_CLOSE: closed_q = 1'b1;
            OP_REOPEN:
            begin
                for (int i = 0; i < NSLOT; i++)
                    if (used_q[i] && shown_q[i]) r.status = ST_REOPEN_REF;
                if (r.status == ST_OK) closed_q = 1'b0;
            end
            default: r.is_tracked = find_exact(a, l) >= 0;
        endcase
        return r;
    endfunction

    // Predict on accepted requests, compare accepted results
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            fail_count = 0;
            answers_due.delete();
            namespace_q = 64'd0;
            seq_q = 64'd1;
            closed_q = 1'b0;
            for (int i = 0; i < NSLOT; i++)
            begin
                used_q[i] = 1'b0; shown_q[i] = 1'b0; leases_q[i] = 16'd0;
                base_q[i] = 64'd0; len_q[i] = 64'd0; mode_q[i] = 2'd0; id_q[i] = 64'd0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready) namespace_q = cfg_data;
            if (push && !full)
                answers_due.push_back(lease_answer(op_t'(kind), address, byte_length,
                    access_mode, presented_id, is_write, lease_slot));
            if (pop && !empty)
            begin
                if (answers_due.size() == 0)
                begin
                    $display("%0t: result transaction with nothing expected", $realtime);
                    fail_count++;
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (status != want.status)
                        report("status", 64'(status), 64'(want.status));
                    if (assigned_id != want.assigned_id)
                        report("assigned_id", assigned_id, want.assigned_id);
                    if (handle_slot != want.handle_slot)
                        report("handle_slot", 64'(handle_slot), 64'(want.handle_slot));
                    if (region_base != want.region_base)
                        report("region_base", region_base, want.region_base);
                    if (region_length != want.region_length)
                        report("region_length", region_length, want.region_length);
                    if (is_tracked != want.is_tracked)
                        report("is_tracked", 64'(is_tracked), 64'(want.is_tracked));
                    if (drain_done != want.drain_done)
                        report("drain_done", 64'(drain_done), 64'(want.drain_done));
                end
            end
        end
    end
endmodule

### tb/buffer_region_lease_table_tb.sv
// Top of the buffer region lease table testbench: clock, reset, stimulus and
// verdict. Depends on brlt_pkg, the block and buffer_region_lease_table_checker.
module buffer_region_lease_table_tb
    import brlt_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    logic        clk, rst_n, push, full, empty, pop, cfg_valid, cfg_ready;
    logic [2:0]  kind;
    logic [63:0] address, byte_length, presented_id, cfg_data;
    logic [1:0]  access_mode;
    logic        is_write;
    logic [3:0]  lease_slot;
    logic [3:0]  status, handle_slot;
    logic [63:0] assigned_id, region_base, region_length;
    logic        is_tracked, drain_done;
    int          fail_count, pending, cycles;
    bit          hold_results;
    logic [63:0] known_base [8];
    logic [63:0] known_len [8];

    buffer_region_lease_table u_dut (.*);

    buffer_region_lease_table_checker u_chk (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Stop a hung run
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("buffer_region_lease_table verification failed");
                $finish;
            end
        end
    end

    // Pick a gap length: mostly none or short, now and then long
    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    // Drain results with random stalls
    initial
    begin
        int g;
        pop = 0;
        forever
        begin
            @(negedge clk);
            if (hold_results)
                pop <= 0;
            else if ($urandom_range(3) != 0)
                pop <= 1;
            else
            begin
                g = gap_len();
                pop <= 0;
                repeat (g) @(negedge clk);
            end
        end
    end

    // Offer one request and hold it until accepted; push stays high into a
    // back-to-back follower
    task automatic send_req(input op_t op, input logic [63:0] a, input logic [63:0] l,
            input logic [1:0] m, input logic [63:0] rid, input logic wr,
            input logic [3:0] ls);
        int g;
        kind <= op; address <= a; byte_length <= l; access_mode <= m;
        presented_id <= rid; is_write <= wr; lease_slot <= ls;
        push <= 1;
        do @(posedge clk); while (full);
        @(negedge clk);
        g = gap_len();
        if (g != 0)
        begin
            push <= 0;
            repeat (g) @(negedge clk);
        end
    endtask

    // Write the namespace once the block is idle
    task automatic write_namespace(input logic [63:0] v);
        push <= 0;
        while (pending != 0) @(negedge clk);
        repeat (30) @(negedge clk);
        cfg_data <= v;
        cfg_valid <= 1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    // Random request, mostly aimed at a small set of known regions
    task automatic random_req();
        int k, p;
        logic [63:0] a, l, rid;
        k = $urandom_range(7);
        p = $urandom_range(99);
        a = known_base[k];
        l = known_len[k];
        if (p < 60)
        begin
            case ($urandom_range(9))
                0, 1: send_req(OP_ADD, a, l, 2'($urandom_range(3)), 0, 0, 0);
                2: send_req(OP_REMOVE, a, l, 0, 0, 0, 0);
                3: send_req(OP_ACQ_LOC, a + 64'($urandom_range(15)),
                    64'($urandom_range(1, 48)), 0, 0, 0, 0);
                4, 5:
                begin
                    // Present the live id of the region most of the time
                    rid = {$urandom, $urandom};
                    if ($urandom_range(3) != 0)
                        for (int i = 0; i < 16; i++)
                            if (u_chk.used_q[i] && u_chk.base_q[i] == a)
                                rid = u_chk.id_q[i];
                    send_req(OP_ACQ_REM, a + 64'($urandom_range(15)),
                        64'($urandom_range(1, 48)), 0, rid, 1'($urandom_range(1)), 0);
                end
                6, 7: send_req(OP_RELEASE, 0, 0, 0, 0, 0, 4'($urandom_range(15)));
                8: send_req(OP_QUERY, a, l, 0, 0, 0, 0);
                default: send_req(($urandom_range(1) != 0) ? OP_CLOSE : OP_REOPEN,
                    0, 0, 0, 0, 0, 0);
            endcase
        end
        else
            send_req(op_t'($urandom_range(7)), {$urandom, $urandom},
                ($urandom_range(1) != 0) ? 64'($urandom_range(1, 256)) : {$urandom, $urandom},
                2'($urandom_range(3)), {$urandom, $urandom}, 1'($urandom_range(1)),
                4'($urandom_range(15)));
    endtask

    initial
    begin
        int r;
        rst_n = 0;
        push = 0; kind = 0; address = 0; byte_length = 0; access_mode = 0;
        presented_id = 0; is_write = 0; lease_slot = 0;
        cfg_valid = 0; cfg_data = 0; hold_results = 0;
        for (int i = 0; i < 8; i++)
        begin
            known_base[i] = 64'h1000 * (i + 1);
            known_len[i] = 64'h40;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: namespace zero, ids follow the sequence
        write_namespace(64'h0);
        send_req(OP_ADD, 0, 0, 0, 0, 0, 0);
        send_req(OP_ADD, 64'hFFFF_FFFF_FFFF_FFF0, 64'h20, 0, 0, 0, 0);
        send_req(OP_ADD, 64'hFFFF_FFFF_FFFF_FFF0, 64'h10, 1, 0, 0, 0);
        send_req(OP_ADD, 64'h1000, 64'h40, MODE_INVALID, 0, 0, 0);
        send_req(OP_ADD, 64'h1000, 64'h40, MODE_LOCAL_RW, 0, 0, 0);
        send_req(OP_ADD, 64'h1020, 64'h40, 1, 0, 0, 0);
        send_req(OP_ADD, 64'h2000, 64'h40, MODE_GLOBAL_RW, 0, 0, 0);
        send_req(OP_ACQ_LOC, 64'h1000, 64'h40, 0, 0, 0, 0);
        send_req(OP_ACQ_LOC, 64'h1000, 0, 0, 0, 0, 0);
        send_req(OP_ACQ_LOC, 64'h5000, 64'h4, 0, 0, 0, 0);
        send_req(OP_ACQ_REM, 64'h1000, 64'h4, 0, 64'h1, 0, 0);
        send_req(OP_ACQ_REM, 64'h2000, 64'h4, 0, 64'h9, 1, 0);
        send_req(OP_ACQ_REM, 64'h2000, 64'h4, 0, 64'h3, 1, 0);
        send_req(OP_REMOVE, 64'h2000, 64'h40, 0, 0, 0, 0);
        send_req(OP_ADD, 64'h2000, 64'h40, 1, 0, 0, 0);
        send_req(OP_QUERY, 64'h2000, 64'h40, 0, 0, 0, 0);
        send_req(OP_RELEASE, 0, 0, 0, 0, 0, 4'd1);
        send_req(OP_RELEASE, 0, 0, 0, 0, 0, 4'd15);
        send_req(OP_CLOSE, 0, 0, 0, 0, 0, 0);
        send_req(OP_CLOSE, 0, 0, 0, 0, 0, 0);
        send_req(OP_ACQ_LOC, 64'h1000, 64'h4, 0, 0, 0, 0);
        send_req(OP_REOPEN, 0, 0, 0, 0, 0, 0);
        send_req(OP_REMOVE, 64'h1000, 64'h40, 0, 0, 0, 0);
        send_req(OP_REMOVE, 64'h2000, 64'h40, 0, 0, 0, 0);
        send_req(OP_REOPEN, 0, 0, 0, 0, 0, 0);

        // Three adds under namespace two, then the namespace is set to all ones
        write_namespace(64'h2);
        for (int i = 0; i < 3; i++)
            send_req(OP_ADD, 64'h8000 + 64'h100 * i, 64'h10, 1, 0, 0, 0);
        write_namespace(64'hFFFF_FFFF_FFFF_FFFF);

        // Fill the table and hold results back so the input stalls
        hold_results = 1;
        fork
            begin
                repeat (300) @(negedge clk);
                hold_results = 0;
            end
            for (int i = 0; i < 18; i++)
                send_req(OP_ADD, 64'h4_0000 + 64'h100 * i, 64'h80, 2, 0, 0, 0);
        join
        for (int i = 0; i < 18; i++)
            send_req(OP_REMOVE, 64'h4_0000 + 64'h100 * i, 64'h80, 0, 0, 0, 0);

        // Random phases under several namespaces
        for (int ph = 0; ph < 3; ph++)
        begin
            write_namespace(ph == 0 ? 64'h0 : {$urandom, $urandom});
            for (r = 0; r < 160; r++)
                random_req();
        end

        push <= 0;
        while (pending != 0) @(negedge clk);
        repeat (40) @(negedge clk);
        if (fail_count == 0)
            $display("buffer_region_lease_table verification clean");
        else
            $display("buffer_region_lease_table verification failed");
        $finish;
    end
endmodule

### sim.f
rtl/core/brlt_pkg.sv
rtl/core/brlt_front.sv
rtl/core/brlt_engine.sv
rtl/core/buffer_region_lease_table.sv
tb/buffer_region_lease_table_checker.sv
tb/buffer_region_lease_table_tb.sv
